// ===== src/isq_pkg.sv =====
`default_nettype none

package isq_pkg;

    localparam int THREADS_DEF  = 2;
    localparam int CAPACITY_DEF = 16;

    localparam int ACTION_W = 2;
    localparam int THREAD_W = 1;
    localparam int SEQ_W    = 64;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 5;

    // threads that the thread field can name at all
    localparam int THREAD_SPAN = 1 << THREAD_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_MARK   = 2'd1,
        ACT_RETIRE = 2'd2,
        ACT_SQUASH = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        CELL_IDLE,
        CELL_CHECK,
        CELL_MARK,
        CELL_RETIRE,
        CELL_SQUASH
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_POP,
        ST_DONE
    } ctrl_state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        cell_op_t            op;
        logic [THREAD_W-1:0] thread;
        logic [SEQ_W-1:0]    seq;
    } cell_cmd_t;

    typedef struct packed {
        logic hit;
        logic pop;
    } cell_resp_t;

endpackage

`default_nettype wire

// ===== src/isq_req_if.sv =====
`default_nettype none

interface isq_req_if;
    logic                         valid;
    logic                         ready;
    logic [isq_pkg::ACTION_W-1:0] action;
    logic [isq_pkg::THREAD_W-1:0] thread;
    logic [isq_pkg::SEQ_W-1:0]    seq_num;
    logic                         has_slot;
    logic [isq_pkg::SLOT_W-1:0]   slot;

    modport source (output valid, action, thread, seq_num, has_slot, slot, input ready);
    modport sink   (input valid, action, thread, seq_num, has_slot, slot, output ready);
endinterface

`default_nettype wire

// ===== src/isq_rsp_if.sv =====
`default_nettype none

interface isq_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        accepted;
    logic [isq_pkg::SLOT_W-1:0]  slot_out;
    logic [isq_pkg::COUNT_W-1:0] removed;
    logic [isq_pkg::COUNT_W-1:0] occupancy;

    modport source (output valid, accepted, slot_out, removed, occupancy, input ready);
    modport sink   (input valid, accepted, slot_out, removed, occupancy, output ready);
endinterface

`default_nettype wire

// ===== src/inorder_slot_queue_retire_squash.sv =====
// In-order slot queue per hardware thread, with commit retirement and squash.
// req channel: one transfer carries an action (allocate, mark finished,
// retire committed, squash), the thread, a sequence number and the slot the
// instruction may already hold. rsp channel: one result per request with the
// accepted flag, the allocated slot, the number of entries removed and the
// thread's occupancy afterwards.
// The slots form a ring of cells; retire walks a token forwards from the
// head and squash walks it backwards from the tail, one entry per cycle.
// Allocate and mark finished: the request is registered and ST_CHECK checks
// the cells. Retire and squash: ST_POP pops entries (at most CAPACITY) until
// the walk meets an entry it keeps or the queue empties. ST_DONE then moves
// the result to the output register; a new request is taken in the cycle after
// that, so the block works on one request at a time.
// When rsp is stalled the result waits in the output register and the next
// request is still taken and worked on; only its own result then waits.
// Reset empties every queue (live and finished flags, pointers and counts).
`default_nettype none

module inorder_slot_queue_retire_squash #(
    parameter int THREADS  = isq_pkg::THREADS_DEF,
    parameter int CAPACITY = isq_pkg::CAPACITY_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    isq_req_if.sink    req,
    isq_rsp_if.source  rsp
);

    localparam int USED_THREADS = (THREADS < isq_pkg::THREAD_SPAN)
                                  ? THREADS : isq_pkg::THREAD_SPAN;

    isq_pkg::cell_cmd_t   cmd;
    logic [CAPACITY-1:0]  inj;
    logic [CAPACITY-1:0]  wr;
    logic [CAPACITY-1:0]  fwd;
    logic [CAPACITY-1:0]  bwd;
    isq_pkg::cell_resp_t  resp [CAPACITY];

    isq_ctrl #(
        .THREADS      (THREADS),
        .CAPACITY     (CAPACITY),
        .USED_THREADS (USED_THREADS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .inj   (inj),
        .wr    (wr),
        .resp  (resp)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam int PREV = (i + CAPACITY - 1) % CAPACITY;
        localparam int NEXT = (i + 1) % CAPACITY;

        isq_cell #(
            .USED_THREADS (USED_THREADS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .inj     (inj[i]),
            .wr      (wr[i]),
            .fwd_in  (fwd[PREV]),
            .bwd_in  (bwd[NEXT]),
            .fwd_out (fwd[i]),
            .bwd_out (bwd[i]),
            .resp    (resp[i])
        );
    end

endmodule

`default_nettype wire

// ===== src/isq_cell.sv =====
`default_nettype none

// One queue slot, holding that slot's entry for every thread. A token
// walks the ring: forwards from the head on retire, backwards from the
// tail on squash; it moves on only when this cell pops its entry.
module isq_cell #(
    parameter int USED_THREADS = isq_pkg::THREADS_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  isq_pkg::cell_cmd_t   cmd,
    input  wire                  inj,
    input  wire                  wr,
    input  wire                  fwd_in,
    input  wire                  bwd_in,
    output logic                 fwd_out,
    output logic                 bwd_out,
    output isq_pkg::cell_resp_t  resp
);

    localparam int TIDX_W = (USED_THREADS > 1) ? $clog2(USED_THREADS) : 1;

    logic [USED_THREADS-1:0]      live_reg;
    logic [USED_THREADS-1:0]      live_next;
    logic [USED_THREADS-1:0]      done_reg;
    logic [USED_THREADS-1:0]      done_next;
    logic [isq_pkg::SEQ_W-1:0]    order_reg [USED_THREADS];
    logic                         tok_reg;
    logic                         tok_next;

    logic [TIDX_W-1:0]            tidx;
    logic                         match;
    logic                         pop;

    assign tidx  = cmd.thread[TIDX_W-1:0];
    assign match = live_reg[tidx] && (order_reg[tidx] == cmd.seq);

    always_comb
    begin
        live_next = live_reg;
        done_next = done_reg;
        pop       = 1'b0;
        resp.hit  = 1'b0;
        unique case (cmd.op)
            isq_pkg::CELL_CHECK:
            begin
                resp.hit = tok_reg && match;
            end
            isq_pkg::CELL_MARK:
            begin
                resp.hit = tok_reg && match;
                if (tok_reg && match)
                begin
                    done_next[tidx] = 1'b1;
                end
            end
            isq_pkg::CELL_RETIRE:
            begin
                pop = tok_reg && done_reg[tidx] && (order_reg[tidx] <= cmd.seq);
            end
            isq_pkg::CELL_SQUASH:
            begin
                pop = tok_reg && (order_reg[tidx] > cmd.seq);
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
        if (pop)
        begin
            live_next[tidx] = 1'b0;
            done_next[tidx] = 1'b0;
        end
        if (wr)
        begin
            live_next[tidx] = 1'b1;
            done_next[tidx] = 1'b0;
        end
        resp.pop = pop;
        fwd_out  = pop && (cmd.op == isq_pkg::CELL_RETIRE);
        bwd_out  = pop && (cmd.op == isq_pkg::CELL_SQUASH);
        tok_next = inj
                   || (fwd_in && (cmd.op == isq_pkg::CELL_RETIRE))
                   || (bwd_in && (cmd.op == isq_pkg::CELL_SQUASH));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
            done_reg <= '0;
            tok_reg  <= 1'b0;
        end
        else
        begin
            live_reg <= live_next;
            done_reg <= done_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            order_reg[tidx] <= cmd.seq;
        end
    end

endmodule

`default_nettype wire

// ===== src/isq_ctrl.sv =====
`default_nettype none

// Per-thread head/tail/count bookkeeping, sequencing of the cell ring and
// the result register.
module isq_ctrl #(
    parameter int THREADS      = isq_pkg::THREADS_DEF,
    parameter int CAPACITY     = isq_pkg::CAPACITY_DEF,
    parameter int USED_THREADS = isq_pkg::THREADS_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    isq_req_if.sink              req,
    isq_rsp_if.source            rsp,
    output isq_pkg::cell_cmd_t   cmd,
    output logic [CAPACITY-1:0]  inj,
    output logic [CAPACITY-1:0]  wr,
    input  isq_pkg::cell_resp_t  resp [CAPACITY]
);

    localparam int PTR_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int TIDX_W = (USED_THREADS > 1) ? $clog2(USED_THREADS) : 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    isq_pkg::ctrl_state_t            state_reg, state_next;
    isq_pkg::action_t                act_reg, act_next;
    logic [isq_pkg::THREAD_W-1:0]    thr_reg, thr_next;
    logic [isq_pkg::SEQ_W-1:0]       seq_reg, seq_next;
    logic                            bad_reg, bad_next;
    logic [PTR_W-1:0]                head_reg [USED_THREADS];
    logic [PTR_W-1:0]                head_next [USED_THREADS];
    logic [PTR_W-1:0]                next_reg [USED_THREADS];
    logic [PTR_W-1:0]                next_next [USED_THREADS];
    logic [CNT_W-1:0]                count_reg [USED_THREADS];
    logic [CNT_W-1:0]                count_next [USED_THREADS];
    logic [CNT_W-1:0]                removed_reg, removed_next;
    logic                            acc_reg, acc_next;
    logic [isq_pkg::SLOT_W-1:0]      slot_out_reg, slot_out_next;

    logic                            out_valid_reg, out_valid_next;
    logic                            out_acc_reg, out_acc_next;
    logic [isq_pkg::SLOT_W-1:0]      out_slot_reg, out_slot_next;
    logic [isq_pkg::COUNT_W-1:0]     out_removed_reg, out_removed_next;
    logic [isq_pkg::COUNT_W-1:0]     out_occ_reg, out_occ_next;

    logic [TIDX_W-1:0]               tin;
    logic [TIDX_W-1:0]               tcur;
    logic                            thread_ok;
    logic                            slot_ok;
    logic [PTR_W-1:0]                tail_prev;
    logic [PTR_W-1:0]                start_ptr;
    logic                            hit_any;
    logic                            pop_any;

    assign tin       = req.thread[TIDX_W-1:0];
    assign tcur      = thr_reg[TIDX_W-1:0];
    assign thread_ok = int'(req.thread) < THREADS;
    assign slot_ok   = req.has_slot && (int'(req.slot) < CAPACITY);
    assign tail_prev = (next_reg[tin] == '0) ? LAST_PTR : next_reg[tin] - PTR_W'(1);
    assign start_ptr = (isq_pkg::action_t'(req.action) == isq_pkg::ACT_RETIRE)
                       ? head_reg[tin] : tail_prev;

    always_comb
    begin
        hit_any = 1'b0;
        pop_any = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_any = hit_any | resp[i].hit;
            pop_any = pop_any | resp[i].pop;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        thr_next      = thr_reg;
        seq_next      = seq_reg;
        bad_next      = bad_reg;
        head_next     = head_reg;
        next_next     = next_reg;
        count_next    = count_reg;
        removed_next  = removed_reg;
        acc_next      = acc_reg;
        slot_out_next = slot_out_reg;

        out_valid_next   = out_valid_reg && !rsp.ready;
        out_acc_next     = out_acc_reg;
        out_slot_next    = out_slot_reg;
        out_removed_next = out_removed_reg;
        out_occ_next     = out_occ_reg;

        req.ready  = 1'b0;
        inj        = '0;
        wr         = '0;
        cmd.op     = isq_pkg::CELL_IDLE;
        cmd.thread = thr_reg;
        cmd.seq    = seq_reg;

        unique case (state_reg)
            isq_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    act_next      = isq_pkg::action_t'(req.action);
                    thr_next      = req.thread;
                    seq_next      = req.seq_num;
                    bad_next      = !thread_ok;
                    removed_next  = '0;
                    acc_next      = 1'b0;
                    slot_out_next = '0;
                    if (!thread_ok)
                    begin
                        state_next = isq_pkg::ST_DONE;
                    end
                    else
                    begin
                        unique case (isq_pkg::action_t'(req.action))
                            isq_pkg::ACT_ALLOC, isq_pkg::ACT_MARK:
                            begin
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    inj[i] = slot_ok && (int'(req.slot) == i);
                                end
                                state_next = isq_pkg::ST_CHECK;
                            end
                            isq_pkg::ACT_RETIRE, isq_pkg::ACT_SQUASH:
                            begin
                                acc_next = 1'b1;
                                if (count_reg[tin] == '0)
                                begin
                                    state_next = isq_pkg::ST_DONE;
                                end
                                else
                                begin
                                    for (int i = 0; i < CAPACITY; i++)
                                    begin
                                        inj[i] = (int'(start_ptr) == i);
                                    end
                                    state_next = isq_pkg::ST_POP;
                                end
                            end
                        endcase
                    end
                end
            end
            isq_pkg::ST_CHECK:
            begin
                if (act_reg == isq_pkg::ACT_ALLOC)
                begin
                    cmd.op = isq_pkg::CELL_CHECK;
                    if (!hit_any && (count_reg[tcur] < FULL_CNT))
                    begin
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            wr[i] = (int'(next_reg[tcur]) == i);
                        end
                        acc_next          = 1'b1;
                        slot_out_next     = isq_pkg::SLOT_W'(next_reg[tcur]);
                        next_next[tcur]   = (next_reg[tcur] == LAST_PTR)
                                            ? '0 : next_reg[tcur] + PTR_W'(1);
                        count_next[tcur]  = count_reg[tcur] + CNT_W'(1);
                    end
                end
                else
                begin
                    cmd.op   = isq_pkg::CELL_MARK;
                    acc_next = hit_any;
                end
                state_next = isq_pkg::ST_DONE;
            end
            isq_pkg::ST_POP:
            begin
                cmd.op = (act_reg == isq_pkg::ACT_RETIRE)
                         ? isq_pkg::CELL_RETIRE : isq_pkg::CELL_SQUASH;
                if (pop_any)
                begin
                    removed_next     = removed_reg + CNT_W'(1);
                    count_next[tcur] = count_reg[tcur] - CNT_W'(1);
                    if (act_reg == isq_pkg::ACT_RETIRE)
                    begin
                        head_next[tcur] = (head_reg[tcur] == LAST_PTR)
                                          ? '0 : head_reg[tcur] + PTR_W'(1);
                    end
                    else
                    begin
                        next_next[tcur] = (next_reg[tcur] == '0)
                                          ? LAST_PTR : next_reg[tcur] - PTR_W'(1);
                    end
                    if (count_reg[tcur] == CNT_W'(1))
                    begin
                        state_next = isq_pkg::ST_DONE;
                    end
                end
                else
                begin
                    state_next = isq_pkg::ST_DONE;
                end
            end
            isq_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_acc_next     = acc_reg;
                    out_slot_next    = slot_out_reg;
                    out_removed_next = isq_pkg::COUNT_W'(removed_reg);
                    out_occ_next     = bad_reg ? '0 : isq_pkg::COUNT_W'(count_reg[tcur]);
                    state_next       = isq_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= isq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int t = 0; t < USED_THREADS; t++)
            begin
                head_reg[t]  <= '0;
                next_reg[t]  <= '0;
                count_reg[t] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            next_reg      <= next_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg         <= act_next;
        thr_reg         <= thr_next;
        seq_reg         <= seq_next;
        bad_reg         <= bad_next;
        removed_reg     <= removed_next;
        acc_reg         <= acc_next;
        slot_out_reg    <= slot_out_next;
        out_acc_reg     <= out_acc_next;
        out_slot_reg    <= out_slot_next;
        out_removed_reg <= out_removed_next;
        out_occ_reg     <= out_occ_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.accepted  = out_acc_reg;
    assign rsp.slot_out  = out_slot_reg;
    assign rsp.removed   = out_removed_reg;
    assign rsp.occupancy = out_occ_reg;

endmodule

`default_nettype wire

// ===== tb/tb_inorder_slot_queue_retire_squash.sv =====
`timescale 1ns / 100ps

module tb_inorder_slot_queue_retire_squash;

    localparam int THREADS  = isq_pkg::THREADS_DEF;
    localparam int CAPACITY = isq_pkg::CAPACITY_DEF;

    typedef struct packed {
        bit                        accepted;
        bit [isq_pkg::SLOT_W-1:0]  slot_out;
        bit [isq_pkg::COUNT_W-1:0] removed;
        bit [isq_pkg::COUNT_W-1:0] occupancy;
    } queue_result_t;

    // Mirror of the per-thread slot rings, plus the results still owed by the block
    class slot_queue_tracker;
        bit                        live  [THREADS][CAPACITY];
        bit                        done  [THREADS][CAPACITY];
        bit [isq_pkg::SEQ_W-1:0]   order [THREADS][CAPACITY];
        bit [isq_pkg::SLOT_W-1:0]  head  [THREADS];
        bit [isq_pkg::SLOT_W-1:0]  nxt   [THREADS];
        bit [isq_pkg::COUNT_W-1:0] held  [THREADS];
        queue_result_t             owed[$];
        int                        errors;
        int                        checked;
        int                        per_action[4];
        int                        rejected;
        int                        full_rejects;
        int                        max_removed;

        function bit carries_live(bit t, bit [isq_pkg::SEQ_W-1:0] seq, bit has,
                                  bit [isq_pkg::SLOT_W-1:0] s);
            return has && live[t][s] && order[t][s] == seq;
        endfunction

        function void note_request(isq_pkg::action_t act, bit t, bit [isq_pkg::SEQ_W-1:0] seq,
                                   bit has, bit [isq_pkg::SLOT_W-1:0] s);
            queue_result_t            r;
            bit [isq_pkg::SLOT_W-1:0] p;
            bit [isq_pkg::SLOT_W-1:0] tail;
            r = '0;
            per_action[act]++;
            case (act)
                isq_pkg::ACT_ALLOC:
                begin
                    if (held[t] == CAPACITY)
                        full_rejects++;
                    if (!carries_live(t, seq, has, s) && held[t] < CAPACITY)
                    begin
                        p = nxt[t];
                        live[t][p]  = 1'b1;
                        done[t][p]  = 1'b0;
                        order[t][p] = seq;
                        held[t]++;
                        nxt[t] = p + 1'b1;
                        r.accepted = 1'b1;
                        r.slot_out = p;
                    end
                end
                isq_pkg::ACT_MARK:
                begin
                    if (carries_live(t, seq, has, s))
                    begin
                        done[t][s] = 1'b1;
                        r.accepted = 1'b1;
                    end
                end
                isq_pkg::ACT_RETIRE:
                begin
                    r.accepted = 1'b1;
                    while (held[t] != 0)
                    begin
                        p = head[t];
                        if (!done[t][p] || order[t][p] > seq)
                            break;
                        live[t][p] = 1'b0;
                        done[t][p] = 1'b0;
                        head[t] = p + 1'b1;
                        held[t]--;
                        r.removed++;
                    end
                end
                default:
                begin
                    r.accepted = 1'b1;
                    tail = nxt[t];
                    while (held[t] != 0)
                    begin
                        p = tail - 1'b1;
                        if (order[t][p] <= seq)
                            break;
                        live[t][p] = 1'b0;
                        done[t][p] = 1'b0;
                        tail = p;
                        held[t]--;
                        r.removed++;
                    end
                    nxt[t] = tail;
                end
            endcase
            if (!r.accepted)
                rejected++;
            if (r.removed > max_removed)
                max_removed = r.removed;
            r.occupancy = held[t];
            owed.insert(owed.size(), r);
        endfunction

        function void check_result(queue_result_t got);
            queue_result_t want;
            if (owed.size() == 0)
            begin
                $error("result with nothing outstanding: %p", got);
                errors++;
                return;
            end
            want = owed[0];
            owed.delete(0);
            checked++;
            if (got.accepted != want.accepted)
            begin
                $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                errors++;
            end
            if (got.slot_out != want.slot_out)
            begin
                $error("slot_out: expected %0d, got %0d", want.slot_out, got.slot_out);
                errors++;
            end
            if (got.removed != want.removed)
            begin
                $error("removed: expected %0d, got %0d", want.removed, got.removed);
                errors++;
            end
            if (got.occupancy != want.occupancy)
            begin
                $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    isq_req_if req_ch ();
    isq_rsp_if rsp_ch ();

    inorder_slot_queue_retire_squash i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    slot_queue_tracker       tracker;
    bit [isq_pkg::SEQ_W-1:0] seq_ctr [THREADS];
    bit                      steady;
    bit                      stall_request;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("** inorder_slot_queue_retire_squash: FAILED **");
        $finish;
    end

    // transfer monitor: requests feed the tracker, results are checked against it
    always @(posedge clk)
    begin
        if (rst_n && tracker != null)
        begin
            if (req_ch.valid && req_ch.ready)
                tracker.note_request(isq_pkg::action_t'(req_ch.action), req_ch.thread,
                                     req_ch.seq_num, req_ch.has_slot, req_ch.slot);
            if (rsp_ch.valid && rsp_ch.ready)
                tracker.check_result({rsp_ch.accepted, rsp_ch.slot_out, rsp_ch.removed,
                                      rsp_ch.occupancy});
        end
    end

    // result side: random back-pressure, one long hold-off on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (150) @(negedge clk);
            end
            rsp_ch.ready <= steady || ($urandom_range(99) >= 8);
        end
    end

    // entered just after a falling edge; returns at the accepting rising edge
    task automatic drive_request(isq_pkg::action_t act, bit t, bit [isq_pkg::SEQ_W-1:0] seq,
                                 bit has, bit [isq_pkg::SLOT_W-1:0] s);
        while (!steady && $urandom_range(99) < 8)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.thread   <= t;
        req_ch.seq_num  <= seq;
        req_ch.has_slot <= has;
        req_ch.slot     <= s;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic issue(isq_pkg::action_t act, bit t, bit [isq_pkg::SEQ_W-1:0] seq, bit has,
                         bit [isq_pkg::SLOT_W-1:0] s);
        @(negedge clk);
        drive_request(act, t, seq, has, s);
    endtask

    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (tracker.owed.size() != 0)
            @(posedge clk);
    endtask

    function automatic bit pick_live(bit t, output bit [isq_pkg::SLOT_W-1:0] s);
        s = '0;
        if (tracker.held[t] == 0)
            return 1'b0;
        s = tracker.head[t] + isq_pkg::SLOT_W'($urandom_range(tracker.held[t] - 1));
        return 1'b1;
    endfunction

    task automatic random_item();
        isq_pkg::action_t         act;
        bit                       t;
        bit [isq_pkg::SEQ_W-1:0]  seq;
        bit                       has;
        bit [isq_pkg::SLOT_W-1:0] s;
        bit [isq_pkg::SLOT_W-1:0] ls;
        bit                       found;
        int                       pick;
        @(negedge clk);
        t     = 1'($urandom_range(1));
        has   = 1'b0;
        s     = isq_pkg::SLOT_W'($urandom_range(15));
        found = pick_live(t, ls);
        pick  = $urandom_range(99);
        if (pick < 10)
        begin
            // noise: anything the fields allow
            act = isq_pkg::action_t'($urandom_range(3));
            seq = {$urandom, $urandom};
            has = 1'($urandom_range(1));
        end
        else if (pick < 45)
        begin
            act = isq_pkg::ACT_ALLOC;
            seq_ctr[t] += isq_pkg::SEQ_W'($urandom_range(4, 1));
            seq = seq_ctr[t];
            if (found && $urandom_range(9) == 0)
            begin
                // replayed instruction still holding its slot
                has = 1'b1;
                s   = ls;
                seq = tracker.order[t][ls];
            end
            else
                has = ($urandom_range(3) == 0);
        end
        else if (pick < 72)
        begin
            act = isq_pkg::ACT_MARK;
            has = 1'b1;
            if (found && $urandom_range(7) != 0)
            begin
                s   = ls;
                seq = tracker.order[t][ls];
            end
            else
                seq = seq_ctr[t] + 1'b1;
        end
        else if (pick < 90)
        begin
            act = isq_pkg::ACT_RETIRE;
            seq = found ? tracker.order[t][ls] : seq_ctr[t];
            if ($urandom_range(9) == 0)
                seq = '1;
        end
        else
        begin
            act = isq_pkg::ACT_SQUASH;
            seq = found ? tracker.order[t][ls] : seq_ctr[t];
            if ($urandom_range(7) == 0)
                seq = '0;
        end
        drive_request(act, t, seq, has, s);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.action   = isq_pkg::ACT_ALLOC;
        req_ch.thread   = '0;
        req_ch.seq_num  = '0;
        req_ch.has_slot = 1'b0;
        req_ch.slot     = '0;
        steady          = 1'b0;
        stall_request   = 1'b0;
        tracker         = new();
        seq_ctr[0]      = 64'd100;
        seq_ctr[1]      = 64'hFFFF_FFFF_FFFF_0000;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty queues, duplicate and mismatch rejections, wrap, full, whole-queue squash
        issue(isq_pkg::ACT_RETIRE, 1'b0, '0, 1'b0, 4'd0);
        issue(isq_pkg::ACT_SQUASH, 1'b1, '1, 1'b0, 4'd0);
        issue(isq_pkg::ACT_ALLOC,  1'b0, '0, 1'b0, 4'd0);
        issue(isq_pkg::ACT_ALLOC,  1'b0, '1, 1'b1, 4'd9);
        issue(isq_pkg::ACT_ALLOC,  1'b0, '1, 1'b1, 4'd1);
        issue(isq_pkg::ACT_MARK,   1'b0, '0, 1'b1, 4'd0);
        issue(isq_pkg::ACT_MARK,   1'b0, 64'd5, 1'b1, 4'd1);
        issue(isq_pkg::ACT_MARK,   1'b0, '1, 1'b0, 4'd1);
        issue(isq_pkg::ACT_RETIRE, 1'b0, '0, 1'b0, 4'd0);
        for (int i = 1; i <= 15; i++)
            issue(isq_pkg::ACT_ALLOC, 1'b0, isq_pkg::SEQ_W'(i), 1'b0, 4'd15);
        issue(isq_pkg::ACT_ALLOC,  1'b0, 64'd16, 1'b0, 4'd15);
        issue(isq_pkg::ACT_SQUASH, 1'b0, '0, 1'b0, 4'd15);

        for (int i = 0; i < 1100; i++)
        begin
            if (i == 300)
                stall_request = 1'b1;
            if (i == 450 || i == 950)
                drain();
            steady = (i >= 600 && i < 800);
            random_item();
        end
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (tracker.owed.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Run: %0d requests (alloc %0d, mark %0d, retire %0d, squash %0d), %0d checked",
                 tracker.per_action[0] + tracker.per_action[1] + tracker.per_action[2]
                 + tracker.per_action[3], tracker.per_action[0], tracker.per_action[1],
                 tracker.per_action[2], tracker.per_action[3], tracker.checked);
        $display("Run: %0d rejected (%0d on a full queue), largest single pop %0d entries",
                 tracker.rejected, tracker.full_rejects, tracker.max_removed);
        if (tracker.errors == 0 && tracker.owed.size() == 0)
            $display("** inorder_slot_queue_retire_squash: PASSED **");
        else
            $display("** inorder_slot_queue_retire_squash: FAILED **");
        $finish;
    end

endmodule
